>>> hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the elastic sphere collision pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  // component and vector formats
  localparam int COMP_W = 16;
  localparam int VEC_W  = 3 * COMP_W;
  localparam int MASS_W = 16;

  // friction register, unsigned Q1.16
  localparam int                FRIC_W     = 17;
  localparam int                FRIC_SHIFT = 16;
  localparam int                FRIC_HALF  = 1 << (FRIC_SHIFT - 1);
  localparam logic [FRIC_W-1:0] FRIC_ONE   = FRIC_W'(1 << FRIC_SHIFT);

  // projection datapath widths
  localparam int D_W    = COMP_W + 1;             // centre difference
  localparam int DMAG_W = COMP_W;                 // its magnitude
  localparam int DD_W   = 2 * COMP_W + 2;         // squared distance
  localparam int DOT_W  = 2 * COMP_W + 3;         // signed dot product
  localparam int PNUM_W = DOT_W - 1 + DMAG_W;     // projection numerator
  localparam int PQ_W   = COMP_W + 1;             // projection quotient
  localparam int P_W    = PQ_W + 1;               // signed normal part

  // mass formula and tangential widths
  localparam int MSUM_W = MASS_W + 1;
  localparam int MNUM_W = MSUM_W + P_W + 1;       // numerator magnitude
  localparam int MQ_W   = COMP_W + 3;             // mass quotient
  localparam int N_W    = MQ_W + 1;               // signed new normal part
  localparam int W_W    = COMP_W + 3;             // tangential part
  localparam int TT_W   = W_W + FRIC_W + 1;       // scaled tangential product
  localparam int T_W    = TT_W - FRIC_SHIFT;      // rounded tangential part
  localparam int R_W    = T_W + 1;                // unsaturated result

  // pipeline latency
  localparam int FRONT_LAT = 4;
  localparam int PROJ_LAT  = PQ_W + 1;
  localparam int MIX_LAT   = 3;
  localparam int MASS_LAT  = MQ_W + 1;
  localparam int OUT_LAT   = 1;
  localparam int TOTAL_LAT = FRONT_LAT + PROJ_LAT + MIX_LAT + MASS_LAT + OUT_LAT;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef comp_t [2:0]              vec3_t;
  typedef logic signed [P_W-1:0]    pval_t;
  typedef logic signed [N_W-1:0]    nval_t;
  typedef logic signed [T_W-1:0]    tval_t;

  typedef struct packed {
    logic [VEC_W-1:0]  center_1;
    logic [VEC_W-1:0]  center_2;
    logic [VEC_W-1:0]  velocity_1;
    logic [VEC_W-1:0]  velocity_2;
    logic [MASS_W-1:0] mass_1;
    logic [MASS_W-1:0] mass_2;
  } cmd_t;

  typedef struct packed {
    logic [VEC_W-1:0] new_velocity_1;
    logic [VEC_W-1:0] new_velocity_2;
    logic             coincident_flag;
  } result_t;

  // context carried alongside the projection dividers
  typedef struct packed {
    vec3_t             v1;
    vec3_t             v2;
    logic [MASS_W-1:0] m1;
    logic [MASS_W-1:0] m2;
    logic              coinc;
  } ctx_t;

  // context carried alongside the mass dividers
  typedef struct packed {
    tval_t [2:0] t1;
    tval_t [2:0] t2;
    pval_t [2:0] p1;
    pval_t [2:0] p2;
    logic        mzero;
    logic        coinc;
  } mix_ctx_t;

endpackage

>>> hdl/esc_delay.sv
// ----------------------------------------------------------------------------
// esc_delay
// Fixed-length shift line for payload and its valid bit.
// ----------------------------------------------------------------------------
module esc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         vld_in,
  input  logic [W-1:0] d,
  output logic         vld_out,
  output logic [W-1:0] q
);

  logic [DEPTH-1:0] vpipe;
  logic [W-1:0]     pipe [DEPTH];

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[DEPTH-2:0], vld_in};
    end
  end

  // payload taps
  always_ff @(posedge clk) begin
    pipe[0] <= d;
    for (int k = 1; k < DEPTH; k++) begin
      pipe[k] <= pipe[k-1];
    end
  end

  assign vld_out = vpipe[DEPTH-1];
  assign q       = pipe[DEPTH-1];

endmodule

>>> hdl/esc_rdiv.sv
// ----------------------------------------------------------------------------
// esc_rdiv
// Pipelined restoring divider, one quotient bit per stage, rounding to
// nearest with ties away from zero and the sign applied at the end.
// ----------------------------------------------------------------------------
module esc_rdiv #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8,
  parameter int QUO_W = 8
) (
  input  logic                    clk,
  input  logic [NUM_W-1:0]        num,
  input  logic                    neg,
  input  logic [DEN_W-1:0]        den,
  output logic signed [QUO_W:0]   quo
);

  localparam int RW = (NUM_W + 1 > DEN_W + QUO_W) ? NUM_W + 1 : DEN_W + QUO_W;

  logic [RW-1:0]    rem [QUO_W+1];
  logic [DEN_W-1:0] dn  [QUO_W+1];
  logic [QUO_W-1:0] qt  [QUO_W+1];
  logic             ng  [QUO_W+1];

  // entry stage: add half the divisor for rounding
  always_ff @(posedge clk) begin
    rem[0] <= RW'(num) + RW'(den >> 1);
    dn[0]  <= den;
    qt[0]  <= '0;
    ng[0]  <= neg;
  end

  // one trial subtraction per stage, most significant bit first
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int K = QUO_W - 1 - s;
    logic [RW-1:0] sh;
    logic [RW:0]   diff;

    assign sh   = RW'(dn[s]) << K;
    assign diff = {1'b0, rem[s]} - {1'b0, sh};

    always_ff @(posedge clk) begin
      rem[s+1] <= diff[RW] ? rem[s] : diff[RW-1:0];
      qt[s+1]  <= QUO_W'({qt[s], ~diff[RW]});
      dn[s+1]  <= dn[s];
      ng[s+1]  <= ng[s];
    end
  end

  // apply the sign to the magnitude
  assign quo = ng[QUO_W] ? -$signed({1'b0, qt[QUO_W]}) : $signed({1'b0, qt[QUO_W]});

endmodule

>>> hdl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Front stages: centre difference, products, dot products and squared
// distance, then the projection numerators for both velocities.
// ----------------------------------------------------------------------------
module esc_front
  import esc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  cmd_t                   cmd,
  output logic                   out_valid,
  output logic [2:0][PNUM_W-1:0] num1,
  output logic [2:0][PNUM_W-1:0] num2,
  output logic [2:0]             neg1,
  output logic [2:0]             neg2,
  output logic [DD_W-1:0]        dd,
  output ctx_t                   ctx
);

  vec3_t c1, c2;
  logic  s1_valid, s2_valid, s3_valid;
  ctx_t  s1_ctx, s2_ctx, s3_ctx;

  logic signed [D_W-1:0]     s1_d   [3];
  logic signed [D_W-1:0]     s2_d   [3];
  logic signed [2*D_W-1:0]   s2_dsq [3];
  logic signed [2*COMP_W:0]  s2_av1 [3];
  logic signed [2*COMP_W:0]  s2_av2 [3];
  logic [DD_W-1:0]           s3_dd;
  logic signed [DOT_W-1:0]   s3_a1, s3_a2;
  logic [DMAG_W-1:0]         s3_dmag [3];
  logic                      s3_dneg [3];
  logic [DOT_W-2:0]          amag1, amag2;

  assign c1 = vec3_t'(cmd.center_1);
  assign c2 = vec3_t'(cmd.center_2);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // stage 1: unpack and centre difference
  always_ff @(posedge clk) begin
    s1_ctx.v1    <= vec3_t'(cmd.velocity_1);
    s1_ctx.v2    <= vec3_t'(cmd.velocity_2);
    s1_ctx.m1    <= cmd.mass_1;
    s1_ctx.m2    <= cmd.mass_2;
    s1_ctx.coinc <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      s1_d[i] <= {c1[i][COMP_W-1], c1[i]} - {c2[i][COMP_W-1], c2[i]};
    end
  end

  // stage 2: component products
  always_ff @(posedge clk) begin
    s2_ctx <= s1_ctx;
    for (int i = 0; i < 3; i++) begin
      s2_d[i]   <= s1_d[i];
      s2_dsq[i] <= s1_d[i] * s1_d[i];
      s2_av1[i] <= $signed(s1_ctx.v1[i]) * s1_d[i];
      s2_av2[i] <= $signed(s1_ctx.v2[i]) * s1_d[i];
    end
  end

  // stage 3: sums and difference magnitudes
  always_ff @(posedge clk) begin
    s3_ctx <= s2_ctx;
    s3_dd  <= DD_W'(s2_dsq[0]) + DD_W'(s2_dsq[1]) + DD_W'(s2_dsq[2]);
    s3_a1  <= DOT_W'(s2_av1[0]) + DOT_W'(s2_av1[1]) + DOT_W'(s2_av1[2]);
    s3_a2  <= DOT_W'(s2_av2[0]) + DOT_W'(s2_av2[1]) + DOT_W'(s2_av2[2]);
    for (int i = 0; i < 3; i++) begin
      s3_dmag[i] <= s2_d[i][D_W-1] ? DMAG_W'(-s2_d[i]) : DMAG_W'(s2_d[i]);
      s3_dneg[i] <= s2_d[i][D_W-1];
    end
  end

  assign amag1 = s3_a1[DOT_W-1] ? (DOT_W-1)'(-s3_a1) : (DOT_W-1)'(s3_a1);
  assign amag2 = s3_a2[DOT_W-1] ? (DOT_W-1)'(-s3_a2) : (DOT_W-1)'(s3_a2);

  // stage 4: projection numerators, their signs and the coincidence flag
  always_ff @(posedge clk) begin
    ctx.v1    <= s3_ctx.v1;
    ctx.v2    <= s3_ctx.v2;
    ctx.m1    <= s3_ctx.m1;
    ctx.m2    <= s3_ctx.m2;
    ctx.coinc <= (s3_dd == '0);
    dd        <= s3_dd;
    for (int i = 0; i < 3; i++) begin
      num1[i] <= amag1 * s3_dmag[i];
      num2[i] <= amag2 * s3_dmag[i];
      neg1[i] <= s3_a1[DOT_W-1] ^ s3_dneg[i];
      neg2[i] <= s3_a2[DOT_W-1] ^ s3_dneg[i];
    end
  end

endmodule

>>> hdl/esc_mix.sv
// ----------------------------------------------------------------------------
// esc_mix
// Middle stages: tangential parts scaled by friction and the numerators
// of the one-dimensional elastic collision formula.
// ----------------------------------------------------------------------------
module esc_mix
  import esc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  ctx_t                   ctx,
  input  pval_t [2:0]            p1,
  input  pval_t [2:0]            p2,
  input  logic [FRIC_W-1:0]      friction,
  output logic                   out_valid,
  output logic [2:0][MNUM_W-1:0] num1,
  output logic [2:0][MNUM_W-1:0] num2,
  output logic [2:0]             neg1,
  output logic [2:0]             neg2,
  output logic [MSUM_W-1:0]      msum,
  output mix_ctx_t               mctx
);

  localparam int EW = MSUM_W + P_W;

  logic a_valid, b_valid;

  pval_t                     psel1 [3];
  pval_t                     psel2 [3];
  pval_t                     a_p1 [3], a_p2 [3];
  logic signed [W_W-1:0]     a_w1 [3], a_w2 [3];
  logic signed [MSUM_W-1:0]  a_dm, a_m1, a_m2;
  logic [MSUM_W-1:0]         a_msum;
  logic signed [FRIC_W:0]    a_fric;
  logic                      a_coinc;

  pval_t                     b_p1 [3], b_p2 [3];
  logic signed [EW-1:0]      b_e1 [3], b_g1 [3], b_f2 [3], b_g2 [3];
  logic signed [TT_W-1:0]    b_tt1 [3], b_tt2 [3];
  logic [MSUM_W-1:0]         b_msum;
  logic                      b_coinc;

  logic signed [EW+1:0]      sum1 [3], sum2 [3];
  logic [TT_W-2:0]           ttm1 [3], ttm2 [3];
  logic [TT_W-2:0]           ttr1 [3], ttr2 [3];
  tval_t                     tv1 [3], tv2 [3];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  // normal parts are zero for coincident centres
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psel1[i] = ctx.coinc ? pval_t'(0) : p1[i];
      psel2[i] = ctx.coinc ? pval_t'(0) : p2[i];
    end
  end

  // stage a: tangential parts and mass terms
  always_ff @(posedge clk) begin
    a_coinc <= ctx.coinc;
    a_msum  <= {1'b0, ctx.m1} + {1'b0, ctx.m2};
    a_dm    <= {1'b0, ctx.m1} - {1'b0, ctx.m2};
    a_m1    <= {1'b0, ctx.m1};
    a_m2    <= {1'b0, ctx.m2};
    a_fric  <= {1'b0, friction};
    for (int i = 0; i < 3; i++) begin
      a_p1[i] <= psel1[i];
      a_p2[i] <= psel2[i];
      a_w1[i] <= W_W'($signed(ctx.v1[i])) - W_W'(psel1[i]);
      a_w2[i] <= W_W'($signed(ctx.v2[i])) - W_W'(psel2[i]);
    end
  end

  // stage b: products
  always_ff @(posedge clk) begin
    b_coinc <= a_coinc;
    b_msum  <= a_msum;
    for (int i = 0; i < 3; i++) begin
      b_p1[i]  <= a_p1[i];
      b_p2[i]  <= a_p2[i];
      b_e1[i]  <= a_dm * a_p1[i];
      b_g1[i]  <= a_m2 * a_p2[i];
      b_f2[i]  <= a_dm * a_p2[i];
      b_g2[i]  <= a_m1 * a_p1[i];
      b_tt1[i] <= a_w1[i] * a_fric;
      b_tt2[i] <= a_w2[i] * a_fric;
    end
  end

  // numerators, and friction rounding on the magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum1[i] = (EW+2)'(b_e1[i]) + ((EW+2)'(b_g1[i]) <<< 1);
      sum2[i] = ((EW+2)'(b_g2[i]) <<< 1) - (EW+2)'(b_f2[i]);
      ttm1[i] = b_tt1[i][TT_W-1] ? (TT_W-1)'(-b_tt1[i]) : (TT_W-1)'(b_tt1[i]);
      ttm2[i] = b_tt2[i][TT_W-1] ? (TT_W-1)'(-b_tt2[i]) : (TT_W-1)'(b_tt2[i]);
      ttr1[i] = (ttm1[i] + (TT_W-1)'(FRIC_HALF)) >> FRIC_SHIFT;
      ttr2[i] = (ttm2[i] + (TT_W-1)'(FRIC_HALF)) >> FRIC_SHIFT;
      tv1[i]  = $signed({1'b0, ttr1[i][T_W-2:0]});
      tv2[i]  = $signed({1'b0, ttr2[i][T_W-2:0]});
    end
  end

  // stage c: registered to the mass dividers
  always_ff @(posedge clk) begin
    msum       <= b_msum;
    mctx.mzero <= (b_msum == '0);
    mctx.coinc <= b_coinc;
    for (int i = 0; i < 3; i++) begin
      num1[i]    <= sum1[i][EW+1] ? MNUM_W'(-sum1[i]) : MNUM_W'(sum1[i]);
      num2[i]    <= sum2[i][EW+1] ? MNUM_W'(-sum2[i]) : MNUM_W'(sum2[i]);
      neg1[i]    <= sum1[i][EW+1];
      neg2[i]    <= sum2[i][EW+1];
      mctx.t1[i] <= b_tt1[i][TT_W-1] ? -tv1[i] : tv1[i];
      mctx.t2[i] <= b_tt2[i][TT_W-1] ? -tv2[i] : tv2[i];
      mctx.p1[i] <= b_p1[i];
      mctx.p2[i] <= b_p2[i];
    end
  end

endmodule

>>> hdl/esc_out.sv
// ----------------------------------------------------------------------------
// esc_out
// Final stage: normal and tangential parts summed, saturated and packed
// into the result register.
// ----------------------------------------------------------------------------
module esc_out
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  mix_ctx_t    mctx,
  input  nval_t [2:0] q1,
  input  nval_t [2:0] q2,
  output logic        done,
  output result_t     result
);

  localparam logic signed [R_W-1:0] SAT_HI = R_W'((2 ** (COMP_W - 1)) - 1);
  localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);

  nval_t                 n1 [3], n2 [3];
  logic signed [R_W-1:0] r1 [3], r2 [3];
  vec3_t                 o1, o2;

  function automatic comp_t sat(input logic signed [R_W-1:0] x);
    comp_t y;
    if (x > SAT_HI) begin
      y = comp_t'(SAT_HI);
    end else if (x < SAT_LO) begin
      y = comp_t'(SAT_LO);
    end else begin
      y = comp_t'(x);
    end
    return y;
  endfunction

  // zero total mass exchanges the normal parts
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1[i] = mctx.mzero ? N_W'($signed(mctx.p2[i])) : q1[i];
      n2[i] = mctx.mzero ? N_W'($signed(mctx.p1[i])) : q2[i];
      r1[i] = R_W'(n1[i]) + R_W'($signed(mctx.t1[i]));
      r2[i] = R_W'(n2[i]) + R_W'($signed(mctx.t2[i]));
      o1[i] = sat(r1[i]);
      o2[i] = sat(r2[i]);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    result.new_velocity_1  <= o1;
    result.new_velocity_2  <= o2;
    result.coincident_flag <= mctx.coinc;
  end

endmodule

>>> hdl/elastic_sphere_collision.sv
// ----------------------------------------------------------------------------
// elastic_sphere_collision
// Velocity response of two colliding spheres, fully pipelined.
// ----------------------------------------------------------------------------
// One sphere pair is taken in every clock cycle and its result leaves on
// done once it has passed every stage, results in the order the pairs
// went in; busy is high only while reset is held. The depth is set by
// the two bit-per-stage dividers: 18 stages for the projection onto the
// line of centres and 20 for the mass formula, plus four front, three
// middle and one output stage. Results are shown for a single cycle and
// must be taken then. Write the friction register only while no pair is in
// flight.
module elastic_sphere_collision
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  output logic              done,
  output result_t           result,
  input  logic              friction_we,
  input  logic [FRIC_W-1:0] friction_data
);

  logic [FRIC_W-1:0] tangent_friction;

  logic                   front_valid;
  logic [2:0][PNUM_W-1:0] pnum1, pnum2;
  logic [2:0]             pneg1, pneg2;
  logic [DD_W-1:0]        dd;
  ctx_t                   front_ctx, proj_ctx;
  logic                   proj_valid;
  pval_t [2:0]            p1, p2;

  logic                   mix_valid;
  logic [2:0][MNUM_W-1:0] mnum1, mnum2;
  logic [2:0]             mneg1, mneg2;
  logic [MSUM_W-1:0]      msum;
  mix_ctx_t               mix_ctx, mass_ctx;
  logic                   mass_valid;
  nval_t [2:0]            q1, q2;

  assign busy = rst;

  // friction register
  always_ff @(posedge clk) begin
    if (rst) begin
      tangent_friction <= FRIC_ONE;
    end else if (friction_we) begin
      tangent_friction <= friction_data;
    end
  end

  esc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .cmd       (cmd),
    .out_valid (front_valid),
    .num1      (pnum1),
    .num2      (pnum2),
    .neg1      (pneg1),
    .neg2      (pneg2),
    .dd        (dd),
    .ctx       (front_ctx)
  );

  // projection dividers
  for (genvar i = 0; i < 3; i++) begin : g_proj
    esc_rdiv #(.NUM_W(PNUM_W), .DEN_W(DD_W), .QUO_W(PQ_W)) u_div1 (
      .clk (clk),
      .num (pnum1[i]),
      .neg (pneg1[i]),
      .den (dd),
      .quo (p1[i])
    );
    esc_rdiv #(.NUM_W(PNUM_W), .DEN_W(DD_W), .QUO_W(PQ_W)) u_div2 (
      .clk (clk),
      .num (pnum2[i]),
      .neg (pneg2[i]),
      .den (dd),
      .quo (p2[i])
    );
  end

  esc_delay #(.W($bits(ctx_t)), .DEPTH(PROJ_LAT)) u_proj_dly (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (front_valid),
    .d       (front_ctx),
    .vld_out (proj_valid),
    .q       (proj_ctx)
  );

  esc_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (proj_valid),
    .ctx       (proj_ctx),
    .p1        (p1),
    .p2        (p2),
    .friction  (tangent_friction),
    .out_valid (mix_valid),
    .num1      (mnum1),
    .num2      (mnum2),
    .neg1      (mneg1),
    .neg2      (mneg2),
    .msum      (msum),
    .mctx      (mix_ctx)
  );

  // mass formula dividers
  for (genvar i = 0; i < 3; i++) begin : g_mass
    esc_rdiv #(.NUM_W(MNUM_W), .DEN_W(MSUM_W), .QUO_W(MQ_W)) u_div1 (
      .clk (clk),
      .num (mnum1[i]),
      .neg (mneg1[i]),
      .den (msum),
      .quo (q1[i])
    );
    esc_rdiv #(.NUM_W(MNUM_W), .DEN_W(MSUM_W), .QUO_W(MQ_W)) u_div2 (
      .clk (clk),
      .num (mnum2[i]),
      .neg (mneg2[i]),
      .den (msum),
      .quo (q2[i])
    );
  end

  esc_delay #(.W($bits(mix_ctx_t)), .DEPTH(MASS_LAT)) u_mass_dly (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (mix_valid),
    .d       (mix_ctx),
    .vld_out (mass_valid),
    .q       (mass_ctx)
  );

  esc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mass_valid),
    .mctx     (mass_ctx),
    .q1       (q1),
    .q2       (q2),
    .done     (done),
    .result   (result)
  );

endmodule

>>> hdl/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks of latency, strobe and coincidence flag, bound to the
// top level.
// ----------------------------------------------------------------------------
module esc_checker
  import esc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input cmd_t              cmd,
  input logic              done,
  input result_t           result,
  input logic              friction_we
);

  // every transfer in gives one result after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(TOTAL_LAT) done)
    else $error("result missing after accepted transfer");

  // no result without a transfer in
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##(TOTAL_LAT) !done)
    else $error("result without accepted transfer");

  // equal centres raise the flag
  a_coinc_set : assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.center_1 == cmd.center_2)
      |-> ##(TOTAL_LAT) result.coincident_flag)
    else $error("coincident flag not raised");

  // distinct centres leave the flag low
  a_coinc_clr : assert property (@(posedge clk) disable iff (rst || friction_we)
    start && !busy && (cmd.center_1 != cmd.center_2)
      |-> ##(TOTAL_LAT) !result.coincident_flag)
    else $error("coincident flag raised for distinct centres");

endmodule

bind elastic_sphere_collision esc_checker u_esc_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the sphere collision pipeline against a local predictor of the
// projection, mass formula and friction scaling, with random idling.
// ----------------------------------------------------------------------------
module testbench;
  import esc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 2000;
  localparam int DRAIN    = TOTAL_LAT + 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  cmd_t              cmd = '0;
  logic              done;
  result_t           result;
  logic              friction_we = 1'b0;
  logic [FRIC_W-1:0] friction_data = '0;

  // expected responses, oldest first
  result_t           response_q[$];
  logic [FRIC_W-1:0] friction;
  int                mismatches = 0;
  int                sent = 0;
  int                checked = 0;
  int                coincident_seen = 0;
  int                idle_cycles = 0;
  bit                idling_on = 1'b1;

  elastic_sphere_collision u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .friction_we(friction_we),
    .friction_data(friction_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // signed component from a packed vector
  function automatic longint comp_of(logic [VEC_W-1:0] v, int i);
    return longint'($signed(v[i*COMP_W +: COMP_W]));
  endfunction

  // rounded division, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic logic [COMP_W-1:0] saturate(longint x);
    longint top;
    top = (64'sd1 <<< (COMP_W - 1)) - 1;
    if (x > top) x = top;
    if (x < -top - 1) x = -top - 1;
    return x[COMP_W-1:0];
  endfunction

  // collision response of one pair
  function automatic result_t collide(cmd_t c);
    result_t r;
    longint  d[3], v1[3], v2[3], p1[3], p2[3];
    longint  dd, a1, a2, m1, m2, t1, t2, n1, n2, fr;
    fr = longint'(friction);
    m1 = longint'(c.mass_1);
    m2 = longint'(c.mass_2);
    dd = 0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = comp_of(c.center_1, i) - comp_of(c.center_2, i);
      v1[i] = comp_of(c.velocity_1, i);
      v2[i] = comp_of(c.velocity_2, i);
      dd += d[i] * d[i];
    end
    a1 = v1[0] * d[0] + v1[1] * d[1] + v1[2] * d[2];
    a2 = v2[0] * d[0] + v2[1] * d[1] + v2[2] * d[2];
    for (int i = 0; i < 3; i++) begin
      p1[i] = (dd == 0) ? 0 : round_div(a1 * d[i], dd);
      p2[i] = (dd == 0) ? 0 : round_div(a2 * d[i], dd);
      t1 = round_div((v1[i] - p1[i]) * fr, 65536);
      t2 = round_div((v2[i] - p2[i]) * fr, 65536);
      if (m1 + m2 == 0) begin
        n1 = p2[i];
        n2 = p1[i];
      end else begin
        n1 = round_div((m1 - m2) * p1[i] + 2 * m2 * p2[i], m1 + m2);
        n2 = round_div((m2 - m1) * p2[i] + 2 * m1 * p1[i], m1 + m2);
      end
      r.new_velocity_1[i*COMP_W +: COMP_W] = saturate(n1 + t1);
      r.new_velocity_2[i*COMP_W +: COMP_W] = saturate(n2 + t2);
    end
    r.coincident_flag = (dd == 0);
    return r;
  endfunction

  // send one pair, with random idling ahead of it
  task automatic send_pair(cmd_t c);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    response_q.push_back(collide(c));
    sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_friction(logic [FRIC_W-1:0] f);
    friction_we   <= 1'b1;
    friction_data <= f;
    @(posedge clk);
    friction_we <= 1'b0;
    friction    = f;
  endtask

  function automatic logic [VEC_W-1:0] rand_vec(int span);
    logic [VEC_W-1:0] v;
    for (int i = 0; i < 3; i++)
      if (span == 0) v[i*COMP_W +: COMP_W] = COMP_W'($urandom);
      else v[i*COMP_W +: COMP_W] = COMP_W'($urandom_range(0, 2 * span) - span);
    return v;
  endfunction

  function automatic cmd_t rand_pair();
    cmd_t c;
    int   span;
    span = ($urandom_range(0, 2) == 0) ? 0 : 2000;
    c.center_1   = rand_vec(span);
    c.center_2   = ($urandom_range(0, 15) == 0) ? c.center_1 : rand_vec(span);
    c.velocity_1 = rand_vec(span);
    c.velocity_2 = rand_vec(span);
    c.mass_1     = ($urandom_range(0, 7) == 0) ? MASS_W'($urandom_range(0, 3))
                                               : MASS_W'($urandom);
    c.mass_2     = ($urandom_range(0, 7) == 0) ? MASS_W'($urandom_range(0, 3))
                                               : MASS_W'($urandom);
    return c;
  endfunction

  // result checker: every done strobe is a transfer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (response_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        result_t exp_r;
        exp_r = response_q.pop_front();
        checked++;
        if (result.coincident_flag) coincident_seen++;
        if (result.new_velocity_1 !== exp_r.new_velocity_1 ||
            result.new_velocity_2 !== exp_r.new_velocity_2 ||
            result.coincident_flag !== exp_r.coincident_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v1 %h v2 %h f %b, got v1 %h v2 %h f %b",
                     exp_r.new_velocity_1, exp_r.new_velocity_2, exp_r.coincident_flag,
                     result.new_velocity_1, result.new_velocity_2,
                     result.coincident_flag);
        end
      end
    end
  end

  // watchdog on cycles with no transfer either way
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // extremes of every field and the special cases
  task automatic test_directed();
    cmd_t c;
    c = '0;
    c.mass_1 = 16'h0100; c.mass_2 = 16'h0100;
    send_pair(c);                                  // coincident centres
    c.center_1 = 48'h0000_0000_0100;
    c.velocity_1 = 48'h0000_0000_0200;
    send_pair(c);                                  // head-on, equal masses
    c.mass_1 = 0; c.mass_2 = 0;
    send_pair(c);                                  // both masses zero
    c.mass_2 = 16'hFFFF;
    send_pair(c);                                  // one mass zero
    c.mass_1 = 16'hFFFF; c.mass_2 = 1;
    send_pair(c);
    c = '1;
    send_pair(c);
    c.center_1 = {3{16'h7FFF}}; c.center_2 = {3{16'h8000}};
    c.velocity_1 = {3{16'h7FFF}}; c.velocity_2 = {3{16'h8000}};
    send_pair(c);                                  // largest separation
    c.center_1 = {3{16'h8000}}; c.center_2 = {3{16'h7FFF}};
    c.velocity_1 = {3{16'h8000}}; c.velocity_2 = {3{16'h7FFF}};
    c.mass_1 = 1; c.mass_2 = 16'hFFFF;
    send_pair(c);
    c.center_1 = 48'h0001_0000_0000; c.center_2 = '0;
    c.velocity_1 = {16'h8000, 16'h7FFF, 16'h8000};
    send_pair(c);                                  // saturation of the normal part
    for (int i = 0; i < 12; i++) send_pair(rand_pair());
    wait_drained();
  endtask

  task automatic test_friction(logic [FRIC_W-1:0] f, int n);
    set_friction(f);
    for (int i = 0; i < n; i++) send_pair(rand_pair());
    wait_drained();
  endtask

  // one long burst with no idling at all
  task automatic test_back_to_back(int n);
    idling_on = 1'b0;
    for (int i = 0; i < n; i++) send_pair(rand_pair());
    wait_drained();
  endtask

  initial begin
    friction = FRIC_ONE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_friction(17'h1FFFF, 300);
    test_friction('0, 300);
    test_friction(FRIC_ONE, 300);
    test_friction(17'(FRIC_ONE + $urandom_range(1, 65535)), 200);
    test_friction(17'($urandom_range(1, 65535)), 300);
    test_back_to_back(300);
    $display("covered %0d pairs, %0d results checked, %0d with coincident centres",
             sent, checked, coincident_seen);
    $display("friction from zero through unity to the 17-bit maximum");
    if (mismatches == 0 && response_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
